// ===== design/i2cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Types, constants and the phase entry function shared by the I2C bit engine.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

    typedef enum logic [2:0] {
        KIND_IDLE  = 3'd0,
        KIND_START = 3'd1,
        KIND_STOP  = 3'd2,
        KIND_WRITE = 3'd3,
        KIND_WAIT  = 3'd4,
        KIND_READ  = 3'd5
    } kind_t;

    // highest legal request code (read byte)
    localparam logic [2:0]  REQ_LAST        = 3'd4;

    localparam logic [15:0] PHASE_TICKS_RST = 16'd5;
    localparam logic [7:0]  POLL_LIMIT_RST  = 8'd250;

    // register index within the configuration map
    localparam logic REG_PHASE_TICKS = 1'b0;
    localparam logic REG_POLL_LIMIT  = 1'b1;

    typedef struct packed {
        logic       cmd_valid;
        logic [2:0] req_type;
        logic [7:0] tx_byte;
        logic       send_ack;
        logic       sda_in;
    } cmd_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_ok;
        logic       ack_timeout;
    } res_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  phase;
        logic [3:0]  bit_count;
        logic [7:0]  shift;
        logic [15:0] tick;
        logic [8:0]  poll;
        logic        scl;
        logic        sda;
        logic        drv;
        logic        ack_ok;
        logic        timeout;
        logic        ack_level;
        logic [7:0]  rx;
    } eng_t;

    // line levels set on the tick that opens a phase
    function automatic eng_t enter_phase(eng_t s, logic [2:0] p);
        eng_t r;
        r = s;
        r.phase = p;
        unique case (s.kind)
            KIND_START: begin
                if (p == 3'd0) begin
                    r.scl = 1'b1;
                    r.sda = 1'b1;
                    r.drv = 1'b1;
                end else begin
                    r.sda = 1'b0;
                end
            end
            KIND_STOP: begin
                if (p == 3'd0) begin
                    r.scl = 1'b0;
                    r.sda = 1'b0;
                    r.drv = 1'b1;
                end else if (p == 3'd1) begin
                    r.scl = 1'b1;
                end else begin
                    r.sda = 1'b1;
                end
            end
            KIND_WRITE: begin
                if (p == 3'd0) begin
                    r.scl = 1'b0;
                    r.drv = 1'b1;
                end else if (p == 3'd1) begin
                    r.sda   = s.shift[7];
                    r.shift = {s.shift[6:0], 1'b0};
                end else if (p == 3'd2) begin
                    r.scl = 1'b1;
                end else begin
                    r.scl = 1'b0;
                end
            end
            KIND_WAIT: begin
                if (p <= 3'd1) begin
                    r.drv = 1'b0;
                    r.sda = 1'b1;
                end else if (p == 3'd2) begin
                    r.scl = 1'b1;
                end
            end
            KIND_READ: begin
                if (p == 3'd0) begin
                    r.scl = 1'b0;
                    r.drv = 1'b0;
                    r.sda = 1'b1;
                end else if (p == 3'd1) begin
                    r.scl = 1'b1;
                end else if (p == 3'd3) begin
                    r.scl = 1'b0;
                    r.drv = 1'b1;
                    r.sda = ~s.ack_level;
                end else if (p == 3'd4) begin
                    r.scl = 1'b1;
                end
            end
            default: begin
                r = r;
            end
        endcase
        return r;
    endfunction

endpackage

// ===== design/i2cmbe_engine.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_engine
// Line state of the I2C master: advances one tick per accepted request and
// presents the result of that tick.
// ----------------------------------------------------------------------------
module i2cmbe_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  i2cmbe_pkg::cmd_t   cmd,
    input  logic [15:0]        phase_ticks,
    input  logic [7:0]         ack_poll_limit,
    output i2cmbe_pkg::res_t   res
);
    import i2cmbe_pkg::*;

    eng_t        eng_reg;
    eng_t        eng_next;
    logic        done;
    logic [15:0] len;
    logic [15:0] tick_inc;

    assign len      = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;
    assign tick_inc = eng_reg.tick + 16'd1;

    // next state
    always_comb begin
        eng_next = eng_reg;
        done     = 1'b0;
        if (eng_reg.kind == KIND_IDLE) begin
            if (cmd.cmd_valid && (cmd.req_type <= REQ_LAST)) begin
                eng_next.kind      = kind_t'(cmd.req_type + 3'd1);
                eng_next.tick      = '0;
                eng_next.bit_count = '0;
                eng_next.poll      = '0;
                if (eng_next.kind == KIND_WRITE) begin
                    eng_next.shift = cmd.tx_byte;
                end
                if (eng_next.kind == KIND_READ) begin
                    eng_next.shift     = '0;
                    eng_next.ack_level = cmd.send_ack;
                end
                if (eng_next.kind == KIND_WAIT) begin
                    eng_next.ack_ok  = 1'b0;
                    eng_next.timeout = 1'b0;
                end
                eng_next = enter_phase(eng_next, 3'd0);
            end
        end else if (tick_inc < len) begin
            eng_next.tick = tick_inc;
        end else begin
            eng_next.tick = '0;
            unique case (eng_reg.kind)
                KIND_START: begin
                    if (eng_reg.phase == 3'd0) begin
                        eng_next = enter_phase(eng_next, 3'd1);
                    end else begin
                        eng_next.scl = 1'b0;
                        done         = 1'b1;
                    end
                end
                KIND_STOP: begin
                    if (eng_reg.phase < 3'd2) begin
                        eng_next = enter_phase(eng_next, eng_reg.phase + 3'd1);
                    end else begin
                        eng_next.drv = 1'b0;
                        eng_next.sda = 1'b1;
                        done         = 1'b1;
                    end
                end
                KIND_WRITE: begin
                    if (eng_reg.phase < 3'd3) begin
                        eng_next = enter_phase(eng_next, eng_reg.phase + 3'd1);
                    end else begin
                        eng_next.bit_count = eng_reg.bit_count + 4'd1;
                        if (eng_next.bit_count >= 4'd8) begin
                            done = 1'b1;
                        end else begin
                            eng_next = enter_phase(eng_next, 3'd1);
                        end
                    end
                end
                KIND_WAIT: begin
                    if (eng_reg.phase < 3'd2) begin
                        eng_next = enter_phase(eng_next, eng_reg.phase + 3'd1);
                    end else if (!cmd.sda_in) begin
                        eng_next.scl     = 1'b0;
                        eng_next.ack_ok  = 1'b1;
                        eng_next.timeout = 1'b0;
                        done             = 1'b1;
                    end else begin
                        eng_next.poll = eng_reg.poll + 9'd1;
                        if (eng_next.poll > {1'b0, ack_poll_limit}) begin
                            // out of polls: release the bus with a stop
                            eng_next.ack_ok    = 1'b0;
                            eng_next.timeout   = 1'b1;
                            eng_next.kind      = KIND_STOP;
                            eng_next.bit_count = '0;
                            eng_next           = enter_phase(eng_next, 3'd0);
                        end else begin
                            eng_next = enter_phase(eng_next, 3'd3);
                        end
                    end
                end
                KIND_READ: begin
                    if (eng_reg.phase == 3'd0) begin
                        eng_next = enter_phase(eng_next, 3'd1);
                    end else if (eng_reg.phase == 3'd1) begin
                        eng_next.shift = {eng_reg.shift[6:0], cmd.sda_in};
                        eng_next       = enter_phase(eng_next, 3'd2);
                    end else if (eng_reg.phase == 3'd2) begin
                        eng_next.bit_count = eng_reg.bit_count + 4'd1;
                        eng_next = enter_phase(eng_next,
                            (eng_next.bit_count >= 4'd8) ? 3'd3 : 3'd0);
                    end else if (eng_reg.phase == 3'd3) begin
                        eng_next = enter_phase(eng_next, 3'd4);
                    end else begin
                        eng_next.scl = 1'b0;
                        eng_next.rx  = eng_reg.shift;
                        done         = 1'b1;
                    end
                end
                default: begin
                    done = 1'b1;
                end
            endcase
            if (done) begin
                eng_next.kind  = KIND_IDLE;
                eng_next.phase = '0;
            end
        end
    end

    // result of this tick
    always_comb begin
        res.scl_out     = eng_next.scl;
        res.sda_out     = eng_next.sda;
        res.sda_drive   = eng_next.drv;
        res.busy_res    = (eng_next.kind != KIND_IDLE);
        res.done_res    = done;
        res.rx_byte     = eng_next.rx;
        res.ack_ok      = eng_next.ack_ok;
        res.ack_timeout = eng_next.timeout;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eng_reg.kind      <= KIND_IDLE;
            eng_reg.phase     <= '0;
            eng_reg.bit_count <= '0;
            eng_reg.shift     <= '0;
            eng_reg.tick      <= '0;
            eng_reg.poll      <= '0;
            eng_reg.scl       <= 1'b1;
            eng_reg.sda       <= 1'b1;
            eng_reg.drv       <= 1'b0;
            eng_reg.ack_ok    <= 1'b0;
            eng_reg.timeout   <= 1'b0;
            eng_reg.ack_level <= 1'b0;
            eng_reg.rx        <= '0;
        end else if (step_en) begin
            eng_reg <= eng_next;
        end
    end

    a_status_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(eng_reg.ack_ok && eng_reg.timeout))
        else $error("ack_ok and ack_timeout both set");

    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (eng_reg.kind != KIND_IDLE) |-> (eng_reg.phase <= 3'd4))
        else $error("phase index out of range");

    a_timeout_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(eng_reg.timeout) |-> (eng_reg.kind == KIND_STOP))
        else $error("timeout raised without a stop sequence");

    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (eng_reg.kind == KIND_IDLE) |-> (eng_reg.phase == 3'd0))
        else $error("idle engine with nonzero phase");

    a_poll_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_reg.poll <= 9'd256)
        else $error("poll count beyond limit range");

endmodule

// ===== design/i2c_master_bit_engine_unit.sv =====
// the result of a tick request is registered and appears on m_axis in the cycle after it is taken
// throughput: one request per cycle; s_axis_tready drops only while a result waits
// on a stalled m_axis, the single output register being the only buffer
// reset (aresetn low, synchronous): engine idle, SCL high, SDA released,
// phase_ticks 5, ack_poll_limit 250, output register empty
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// I2C master bit engine with stream request/result channels and APB registers.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // cmd_valid, tx_byte[7:0], send_ack, sda_in, zero pad
    input  logic [2:0]  s_axis_tuser,  // req_type[2:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // scl_out, sda_out, sda_drive, busy_res, done_res,
                                       // rx_byte[7:0], ack_ok, ack_timeout, zero pad
);
    import i2cmbe_pkg::*;

    logic [15:0] phase_ticks_reg;
    logic [7:0]  poll_limit_reg;
    logic        cfg_wr;
    logic        step;
    cmd_t        cmd;
    res_t        res;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic [15:0] m_data_reg;
    logic [15:0] m_data_next;

    // configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RST;
            poll_limit_reg  <= POLL_LIMIT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PHASE_TICKS) begin
                phase_ticks_reg <= pwdata[15:0];
            end else begin
                poll_limit_reg <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_POLL_LIMIT) ? {24'd0, poll_limit_reg}
                                                 : {16'd0, phase_ticks_reg};

    // request unpack
    assign cmd.cmd_valid = s_axis_tdata[0];
    assign cmd.tx_byte   = s_axis_tdata[8:1];
    assign cmd.send_ack  = s_axis_tdata[9];
    assign cmd.sda_in    = s_axis_tdata[10];
    assign cmd.req_type  = s_axis_tuser;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    i2cmbe_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (step),
        .cmd            (cmd),
        .phase_ticks    (phase_ticks_reg),
        .ack_poll_limit (poll_limit_reg),
        .res            (res)
    );

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (step) begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, res.ack_timeout, res.ack_ok, res.rx_byte,
                            res.done_res, res.busy_res, res.sda_drive,
                            res.sda_out, res.scl_out};
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_valid_reg)
        else $error("accepted request left no result");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken while result stalled");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        step && res.done_res |-> !res.busy_res)
        else $error("done reported while still busy");

endmodule

// ===== verif/i2c_master_bit_engine_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit_test
// Drives line ticks into the I2C bit engine and checks every output word
// against a tick-level engine model kept here. A directed table comes first,
// then bus transactions with random content across several register settings.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_unit_test;
    import i2cmbe_pkg::*;

    localparam logic [2:0] REQ_START = 3'd0;
    localparam logic [2:0] REQ_STOP  = 3'd1;
    localparam logic [2:0] REQ_WRITE = 3'd2;
    localparam logic [2:0] REQ_WAIT  = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    localparam int MAX_SHOWN = 10;
    localparam int SEGMENTS  = 8;

    // scl, sda, drive, busy, done, rx, ack_ok, ack_timeout
    localparam res_t IDLE_AT_RESET = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
    localparam res_t STOPPED_AFTER_TIMEOUT =
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b1};

    typedef struct {
        logic        v;
        logic [2:0]  req;
        logic [7:0]  tx;
        logic        ack;
        logic        sda;
        int          reps;
        logic        typed;
        res_t        want;
    } drill_row_t;

    typedef struct {
        logic [2:0] req;
        logic [7:0] tx;
        logic       ack;
    } bus_op_t;

    typedef struct {
        kind_t       kind;
        logic [2:0]  phase;
        logic [3:0]  bits;
        logic [7:0]  shreg;
        logic [15:0] ticks;
        int unsigned polls;
        logic        scl;
        logic        sda;
        logic        drv;
        logic        ack_seen;
        logic        timed_out;
        logic        ack_lvl;
        logic [7:0]  rx_last;
    } line_engine_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    line_engine_t eng;
    logic [15:0]  phase_len;
    logic [7:0]   poll_limit;
    res_t         bus_outputs_due [$];
    bus_op_t      transfer_ops [$];

    int  gap_left        = 0;
    bit  calm            = 1'b0;
    int  ticks_sent      = 0;
    int  outputs_checked = 0;
    int  bad_outputs     = 0;
    int  commands_done   = 0;

    drill_row_t drill_rows [21] = '{
        '{1'b0, REQ_START, 8'h00, 1'b0, 1'b1, 1,  1'b1, IDLE_AT_RESET},
        '{1'b1, 3'd5,      8'h00, 1'b0, 1'b0, 1,  1'b1, IDLE_AT_RESET},
        '{1'b1, 3'd7,      8'hff, 1'b1, 1'b1, 1,  1'b1, IDLE_AT_RESET},
        '{1'b1, REQ_START, 8'h00, 1'b0, 1'b1, 1,  1'b0, '0},
        '{1'b1, REQ_WRITE, 8'ha5, 1'b1, 1'b1, 1,  1'b0, '0},
        '{1'b0, REQ_START, 8'h00, 1'b0, 1'b1, 2,  1'b0, '0},
        '{1'b1, REQ_WRITE, 8'hff, 1'b0, 1'b1, 1,  1'b0, '0},
        '{1'b0, REQ_START, 8'h00, 1'b0, 1'b1, 26, 1'b0, '0},
        '{1'b1, REQ_WRITE, 8'h00, 1'b0, 1'b0, 1,  1'b0, '0},
        '{1'b0, REQ_START, 8'h00, 1'b0, 1'b0, 26, 1'b0, '0},
        '{1'b1, REQ_WAIT,  8'h00, 1'b0, 1'b0, 1,  1'b0, '0},
        '{1'b0, REQ_START, 8'h00, 1'b0, 1'b0, 4,  1'b0, '0},
        '{1'b1, REQ_WAIT,  8'h00, 1'b0, 1'b1, 1,  1'b0, '0},
        '{1'b0, REQ_START, 8'h00, 1'b0, 1'b1, 8,  1'b0, '0},
        '{1'b1, REQ_READ,  8'h00, 1'b1, 1'b1, 1,  1'b0, '0},
        '{1'b0, REQ_START, 8'h00, 1'b0, 1'b1, 28, 1'b0, '0},
        '{1'b1, REQ_READ,  8'h00, 1'b0, 1'b0, 1,  1'b0, '0},
        '{1'b0, REQ_START, 8'h00, 1'b0, 1'b0, 28, 1'b0, '0},
        '{1'b1, REQ_STOP,  8'h00, 1'b0, 1'b1, 1,  1'b0, '0},
        '{1'b0, REQ_START, 8'h00, 1'b0, 1'b1, 4,  1'b0, '0},
        '{1'b0, REQ_START, 8'h00, 1'b0, 1'b1, 1,  1'b1, STOPPED_AFTER_TIMEOUT}
    };

    // register settings per random segment, extremes included
    int seg_phase [SEGMENTS] = '{1, 2, 1, 65535, 2, 0, 4, 3};
    int seg_polls [SEGMENTS] = '{2, 1, 255, 4, 4, 0, 6, 250};
    int seg_len   [SEGMENTS] = '{260, 200, 260, 30, 180, 150, 160, 160};

    i2c_master_bit_engine_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // line levels that show on the tick opening phase p
    function automatic void open_phase(logic [2:0] p);
        eng.phase = p;
        case (eng.kind)
            KIND_START: begin
                if (p == 3'd0) begin
                    eng.scl = 1'b1;
                    eng.sda = 1'b1;
                    eng.drv = 1'b1;
                end else begin
                    eng.sda = 1'b0;
                end
            end
            KIND_STOP: begin
                if (p == 3'd0) begin
                    eng.scl = 1'b0;
                    eng.sda = 1'b0;
                    eng.drv = 1'b1;
                end else if (p == 3'd1) begin
                    eng.scl = 1'b1;
                end else begin
                    eng.sda = 1'b1;
                end
            end
            KIND_WRITE: begin
                if (p == 3'd0) begin
                    eng.scl = 1'b0;
                    eng.drv = 1'b1;
                end else if (p == 3'd1) begin
                    eng.sda   = eng.shreg[7];
                    eng.shreg = eng.shreg << 1;
                end else if (p == 3'd2) begin
                    eng.scl = 1'b1;
                end else begin
                    eng.scl = 1'b0;
                end
            end
            KIND_WAIT: begin
                if (p <= 3'd1) begin
                    eng.drv = 1'b0;
                    eng.sda = 1'b1;
                end else if (p == 3'd2) begin
                    eng.scl = 1'b1;
                end
            end
            KIND_READ: begin
                if (p == 3'd0) begin
                    eng.scl = 1'b0;
                    eng.drv = 1'b0;
                    eng.sda = 1'b1;
                end else if (p == 3'd1) begin
                    eng.scl = 1'b1;
                end else if (p == 3'd3) begin
                    eng.scl = 1'b0;
                    eng.drv = 1'b1;
                    eng.sda = eng.ack_lvl ? 1'b0 : 1'b1;
                end else if (p == 3'd4) begin
                    eng.scl = 1'b1;
                end
            end
            default: begin
            end
        endcase
    endfunction

    // closes the current phase; returns 1 when the command is complete
    function automatic logic close_phase(logic sda_now);
        logic [2:0] p;
        p = eng.phase;
        case (eng.kind)
            KIND_START: begin
                if (p == 3'd0) begin
                    open_phase(3'd1);
                    return 1'b0;
                end
                eng.scl = 1'b0;
                return 1'b1;
            end
            KIND_STOP: begin
                if (p < 3'd2) begin
                    open_phase(p + 3'd1);
                    return 1'b0;
                end
                eng.drv = 1'b0;
                eng.sda = 1'b1;
                return 1'b1;
            end
            KIND_WRITE: begin
                if (p < 3'd3) begin
                    open_phase(p + 3'd1);
                    return 1'b0;
                end
                eng.bits = eng.bits + 4'd1;
                if (eng.bits >= 4'd8) return 1'b1;
                open_phase(3'd1);
                return 1'b0;
            end
            KIND_WAIT: begin
                if (p < 3'd2) begin
                    open_phase(p + 3'd1);
                    return 1'b0;
                end
                if (!sda_now) begin
                    eng.scl       = 1'b0;
                    eng.ack_seen  = 1'b1;
                    eng.timed_out = 1'b0;
                    return 1'b1;
                end
                eng.polls = eng.polls + 1;
                if (eng.polls > poll_limit) begin
                    // out of polls: flag it and release the bus with a stop
                    eng.ack_seen  = 1'b0;
                    eng.timed_out = 1'b1;
                    eng.kind      = KIND_STOP;
                    eng.bits      = 4'd0;
                    open_phase(3'd0);
                    return 1'b0;
                end
                open_phase(3'd3);
                return 1'b0;
            end
            KIND_READ: begin
                if (p == 3'd0) begin
                    open_phase(3'd1);
                    return 1'b0;
                end
                if (p == 3'd1) begin
                    eng.shreg = {eng.shreg[6:0], sda_now};
                    open_phase(3'd2);
                    return 1'b0;
                end
                if (p == 3'd2) begin
                    eng.bits = eng.bits + 4'd1;
                    open_phase(eng.bits >= 4'd8 ? 3'd3 : 3'd0);
                    return 1'b0;
                end
                if (p == 3'd3) begin
                    open_phase(3'd4);
                    return 1'b0;
                end
                eng.scl     = 1'b0;
                eng.rx_last = eng.shreg;
                return 1'b1;
            end
            default: return 1'b1;
        endcase
    endfunction

    function automatic res_t step_line_engine(logic v, logic [2:0] req, logic [7:0] tx,
                                              logic ack, logic sda_now);
        res_t        r;
        logic        fin;
        logic [15:0] len;
        fin = 1'b0;
        if (eng.kind == KIND_IDLE) begin
            if (v && req <= REQ_LAST) begin
                eng.kind  = kind_t'(req + 3'd1);
                eng.ticks = '0;
                eng.bits  = '0;
                eng.polls = 0;
                if (eng.kind == KIND_WRITE) eng.shreg = tx;
                if (eng.kind == KIND_READ) begin
                    eng.shreg   = '0;
                    eng.ack_lvl = ack;
                end
                if (eng.kind == KIND_WAIT) begin
                    eng.ack_seen  = 1'b0;
                    eng.timed_out = 1'b0;
                end
                open_phase(3'd0);
            end
        end else begin
            len = (phase_len == 16'd0) ? 16'd1 : phase_len;
            eng.ticks = eng.ticks + 16'd1;
            if (eng.ticks >= len) begin
                eng.ticks = '0;
                if (close_phase(sda_now)) begin
                    eng.kind  = KIND_IDLE;
                    eng.phase = '0;
                    fin       = 1'b1;
                end
            end
        end
        r.scl_out     = eng.scl;
        r.sda_out     = eng.sda;
        r.sda_drive   = eng.drv;
        r.busy_res    = (eng.kind != KIND_IDLE);
        r.done_res    = fin;
        r.rx_byte     = eng.rx_last;
        r.ack_ok      = eng.ack_seen;
        r.ack_timeout = eng.timed_out;
        return r;
    endfunction

    task automatic apb_write(input logic idx, input logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        while (!pready) @(negedge aclk);
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_PHASE_TICKS) phase_len = val[15:0];
        else poll_limit = val[7:0];
    endtask

    // offers one line tick; valid stays high when the next tick follows at once
    task automatic send_tick(input logic v, input logic [2:0] req, input logic [7:0] tx,
                             input logic ack, input logic sda_now, input logic typed,
                             input res_t want, input logic last);
        res_t pred;
        repeat (gap_left) @(posedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, sda_now, ack, tx, v};
        s_axis_tuser  <= req;
        @(negedge aclk);
        while (!s_axis_tready) @(negedge aclk);
        @(posedge aclk);
        pred = step_line_engine(v, req, tx, ack, sda_now);
        bus_outputs_due.push_back(typed ? want : pred);
        ticks_sent++;
        gap_left = calm ? 0 : $urandom_range(0, 5);
        if (last || gap_left != 0) s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (bus_outputs_due.size() != 0) @(posedge aclk);
    endtask

    // output side: random stalls, compare each word with the oldest prediction
    initial begin : output_check
        int   stall;
        res_t got;
        res_t exp_out;
        logic [15:0] word;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            @(negedge aclk);
            while (!m_axis_tvalid) @(negedge aclk);
            word = m_axis_tdata;
            @(posedge aclk);
            got.scl_out     = word[0];
            got.sda_out     = word[1];
            got.sda_drive   = word[2];
            got.busy_res    = word[3];
            got.done_res    = word[4];
            got.rx_byte     = word[12:5];
            got.ack_ok      = word[13];
            got.ack_timeout = word[14];
            if (got.done_res === 1'b1) commands_done++;
            if (bus_outputs_due.size() == 0) begin
                bad_outputs++;
                if (bad_outputs <= MAX_SHOWN)
                    $display("unexpected output word %h with no request pending", word);
            end else begin
                exp_out = bus_outputs_due.pop_front();
                outputs_checked++;
                if (got.scl_out !== exp_out.scl_out || got.sda_out !== exp_out.sda_out ||
                    got.sda_drive !== exp_out.sda_drive ||
                    got.busy_res !== exp_out.busy_res || got.done_res !== exp_out.done_res ||
                    got.rx_byte !== exp_out.rx_byte || got.ack_ok !== exp_out.ack_ok ||
                    got.ack_timeout !== exp_out.ack_timeout) begin
                    bad_outputs++;
                    if (bad_outputs <= MAX_SHOWN) begin
                        $display("output %0d expected scl=%b sda=%b drv=%b busy=%b done=%b rx=%h ack=%b to=%b",
                                 outputs_checked, exp_out.scl_out, exp_out.sda_out,
                                 exp_out.sda_drive, exp_out.busy_res, exp_out.done_res,
                                 exp_out.rx_byte, exp_out.ack_ok, exp_out.ack_timeout);
                        $display("    got scl=%b sda=%b drv=%b busy=%b done=%b rx=%h ack=%b to=%b",
                                 got.scl_out, got.sda_out, got.sda_drive, got.busy_res,
                                 got.done_res, got.rx_byte, got.ack_ok, got.ack_timeout);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        logic       v;
        logic [2:0] req;
        logic [7:0] tx;
        logic       ack;
        logic       sda_now;
        logic       last;
        logic       rd;
        int         pick;
        int         nbytes;
        int         ack_odds;
        bus_op_t    op;

        eng = '{kind: KIND_IDLE, scl: 1'b1, sda: 1'b1, default: '0};
        phase_len  = PHASE_TICKS_RST;
        poll_limit = POLL_LIMIT_RST;
        ack_odds   = 3;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // shortest phases and no polls, so the table runs every command to its end
        apb_write(REG_PHASE_TICKS, 32'd0);
        apb_write(REG_POLL_LIMIT, 32'd0);
        foreach (drill_rows[r]) begin
            for (int k = 0; k < drill_rows[r].reps; k++) begin
                last = (r == $size(drill_rows) - 1) && (k == drill_rows[r].reps - 1);
                send_tick(drill_rows[r].v, drill_rows[r].req, drill_rows[r].tx,
                          drill_rows[r].ack, drill_rows[r].sda, drill_rows[r].typed,
                          drill_rows[r].want, last);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            // the engine may be mid command here; only the output side must be empty
            wait_drained();
            apb_write(REG_PHASE_TICKS, seg_phase[seg]);
            apb_write(REG_POLL_LIMIT, seg_polls[seg]);
            calm = (seg == 2 || seg == 6);
            for (int n = 0; n < seg_len[seg]; n++) begin
                v       = 1'b0;
                req     = 3'($urandom_range(0, 7));
                tx      = 8'($urandom);
                ack     = 1'($urandom_range(0, 1));
                sda_now = 1'($urandom_range(0, 1));
                if (eng.kind == KIND_IDLE) begin
                    pick = $urandom_range(0, 9);
                    if (pick == 1) begin
                        v = 1'b1;  // stray request, unknown codes included
                    end else if (pick > 1) begin
                        if (transfer_ops.size() == 0) begin
                            nbytes = $urandom_range(1, 3);
                            rd     = 1'($urandom_range(0, 1));
                            transfer_ops.push_back('{REQ_START, 8'h00, 1'b0});
                            transfer_ops.push_back('{REQ_WRITE, {tx[7:1], rd}, 1'b0});
                            transfer_ops.push_back('{REQ_WAIT, 8'h00, 1'b0});
                            for (int i = 0; i < nbytes; i++) begin
                                if (rd) begin
                                    transfer_ops.push_back('{REQ_READ, 8'h00, i != nbytes - 1});
                                end else begin
                                    transfer_ops.push_back('{REQ_WRITE, 8'($urandom), 1'b0});
                                    transfer_ops.push_back('{REQ_WAIT, 8'h00, 1'b0});
                                end
                            end
                            transfer_ops.push_back('{REQ_STOP, 8'h00, 1'b0});
                        end
                        op  = transfer_ops.pop_front();
                        v   = 1'b1;
                        req = op.req;
                        tx  = op.tx;
                        ack = op.ack;
                        // a silent slave now and then, to run the poll limit out
                        if (req == REQ_WAIT)
                            ack_odds = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    v = ($urandom_range(0, 3) == 0);
                    if (eng.kind == KIND_WAIT && eng.phase >= 3'd2)
                        sda_now = ($urandom_range(0, 9) < ack_odds) ? 1'b0 : 1'b1;
                end
                last = (n == seg_len[seg] - 1) || (seg == 0 && n == 130);
                send_tick(v, req, tx, ack, sda_now, 1'b0, '0, last);
                if (seg == 0 && n == 130) wait_drained();
            end
        end

        wait_drained();
        repeat (4) @(posedge aclk);
        $display("sent %0d line ticks, checked %0d output words, saw %0d commands complete",
                 ticks_sent, outputs_checked, commands_done);
        $display("phase length swept 0..65535 incl. a mid-phase change, poll limit 0..255");
        if (bad_outputs == 0 && bus_outputs_due.size() == 0) begin
            $display("PASS i2c_master_bit_engine_unit");
        end else begin
            $display("FAIL i2c_master_bit_engine_unit");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("FAIL i2c_master_bit_engine_unit");
        $finish;
    end

endmodule
